>>> hdl/ifd_pkg.sv
// Shared types, constants and the CRC step function of the frame deframer.
package ifd_pkg;

  // Packet layout.
  localparam logic [16:0] POS_MAX     = 17'h1FFFF;
  localparam logic [16:0] FRAME_START = 17'd20;
  localparam logic [17:0] MIN_SIZE    = 18'd37;
  localparam logic [17:0] FRAME_EXTRA = 18'd6;
  localparam logic [17:0] CRC_OFFSET  = 18'd4;
  localparam logic [16:0] WORD_LO_POS = 17'd35;
  localparam logic [16:0] WORD_HI_POS = 17'd36;
  localparam logic [7:0]  PREFIX_0    = 8'hA1;
  localparam logic [7:0]  PREFIX_1    = 8'h1A;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;

  // Configuration register indexes.
  localparam logic [7:0] CFG_DATA_FUNC = 8'd0;
  localparam logic [7:0] CFG_READ_FUNC = 8'd1;

  // Field codes assigned to a byte by the front end.
  localparam logic [3:0] FLD_NONE     = 4'd0;
  localparam logic [3:0] FLD_PREFIX0  = 4'd1;
  localparam logic [3:0] FLD_PREFIX1  = 4'd2;
  localparam logic [3:0] FLD_LEN_LO   = 4'd3;
  localparam logic [3:0] FLD_LEN_HI   = 4'd4;
  localparam logic [3:0] FLD_TCP_FUNC = 4'd5;
  localparam logic [3:0] FLD_DEV_FUNC = 4'd6;
  localparam logic [3:0] FLD_START_LO = 4'd7;
  localparam logic [3:0] FLD_START_HI = 4'd8;
  localparam logic [3:0] FLD_WORD_LO  = 4'd9;
  localparam logic [3:0] FLD_WORD_HI  = 4'd10;

  // Verdict codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_PREFIX   = 3'd2;
  localparam logic [2:0] ST_LENGTH   = 3'd3;
  localparam logic [2:0] ST_TCP_FUNC = 3'd4;
  localparam logic [2:0] ST_CRC      = 3'd5;
  localparam logic [2:0] ST_DEV_FUNC = 3'd6;

  // Result kinds.
  localparam logic KIND_WORD    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // A classified byte as it passes from front end to back end.
  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        eop;
    logic [16:0] pos;
    logic [3:0]  field;
    logic        crc_on;
  } item_t;

  // One result item.
  typedef struct packed {
    logic        kind;
    logic [15:0] reg_address;
    logic [15:0] reg_value;
    logic [2:0]  status;
  } result_t;

  // Reflected CRC-16 over one byte, eight shift steps unrolled.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> hdl/ifd_front.sv
// Front end: tracks the byte position, classifies each byte and queues it.
module ifd_front import ifd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [7:0]  rx_byte,
  input  logic        end_of_packet,
  output logic        full,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_take
);

  logic [16:0] pos;
  logic [16:0] pos_next;
  logic        accept;
  item_t       cls;
  item_t       q_mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full    = (count == 2'd2);
  assign accept  = push && !full;
  assign q_valid = (count != 2'd0);
  assign q_item  = q_mem[rd_ptr];

  // Classify the byte by its position in the packet.
  always_comb begin
    cls.rx_byte = rx_byte;
    cls.eop     = end_of_packet;
    cls.pos     = pos;
    cls.crc_on  = (pos >= FRAME_START + 17'd2);
    if (pos == 17'd0) begin
      cls.field = FLD_PREFIX0;
    end else if (pos == 17'd1) begin
      cls.field = FLD_PREFIX1;
    end else if (pos == 17'd4) begin
      cls.field = FLD_LEN_LO;
    end else if (pos == 17'd5) begin
      cls.field = FLD_LEN_HI;
    end else if (pos == 17'd7) begin
      cls.field = FLD_TCP_FUNC;
    end else if (pos == FRAME_START + 17'd1) begin
      cls.field = FLD_DEV_FUNC;
    end else if (pos == FRAME_START + 17'd12) begin
      cls.field = FLD_START_LO;
    end else if (pos == FRAME_START + 17'd13) begin
      cls.field = FLD_START_HI;
    end else if (pos >= WORD_LO_POS && pos[0]) begin
      cls.field = FLD_WORD_LO;
    end else if (pos >= WORD_HI_POS && !pos[0]) begin
      cls.field = FLD_WORD_HI;
    end else begin
      cls.field = FLD_NONE;
    end
  end

  // Position counter saturates and returns to zero after the final byte.
  always_comb begin
    pos_next = pos;
    if (accept) begin
      if (end_of_packet) begin
        pos_next = 17'd0;
      end else if (pos != POS_MAX) begin
        pos_next = pos + 17'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= 17'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      pos <= pos_next;
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_take) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({accept, q_take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (accept) begin
      q_mem[wr_ptr] <= cls;
    end
  end

endmodule

>>> hdl/ifd_back.sv
// Back end: captures fields, runs the CRC, builds results and queues them.
module ifd_back import ifd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_take,
  input  logic        cfg_valid,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        pop,
  output logic        empty,
  output result_t     res_head
);

  logic [7:0]  data_func;
  logic [7:0]  read_func;
  logic [15:0] decl_len;
  logic [15:0] decl_len_next;
  logic        prefix_bad;
  logic        prefix_bad_next;
  logic [7:0]  tcp_func;
  logic [7:0]  tcp_func_next;
  logic [7:0]  dev_func;
  logic [7:0]  dev_func_next;
  logic [15:0] start_reg;
  logic [15:0] start_reg_next;
  logic [7:0]  low_hold;
  logic [15:0] crc;
  logic [15:0] crc_next;
  logic [15:0] tail;
  logic [15:0] tail_next;
  logic [16:0] word_off;
  logic [17:0] size;
  logic        res_we;
  result_t     res;
  result_t     r_mem [2];
  logic        r_wr;
  logic        r_rd;
  logic [1:0]  r_count;
  logic        deq;

  assign q_take   = q_valid && (r_count != 2'd2);
  assign empty    = (r_count == 2'd0);
  assign deq      = pop && !empty;
  assign res_head = r_mem[r_rd];
  assign word_off = q_item.pos - WORD_HI_POS;
  assign size     = {1'b0, q_item.pos} + 18'd1;

  // Field captures and CRC update for the byte at hand.
  always_comb begin
    prefix_bad_next = prefix_bad;
    decl_len_next   = decl_len;
    tcp_func_next   = tcp_func;
    dev_func_next   = dev_func;
    start_reg_next  = start_reg;
    case (q_item.field)
      FLD_PREFIX0:  prefix_bad_next = prefix_bad || (q_item.rx_byte != PREFIX_0);
      FLD_PREFIX1:  prefix_bad_next = prefix_bad || (q_item.rx_byte != PREFIX_1);
      FLD_LEN_LO:   decl_len_next   = {decl_len[15:8], q_item.rx_byte};
      FLD_LEN_HI:   decl_len_next   = {q_item.rx_byte, decl_len[7:0]};
      FLD_TCP_FUNC: tcp_func_next   = q_item.rx_byte;
      FLD_DEV_FUNC: dev_func_next   = q_item.rx_byte;
      FLD_START_LO: start_reg_next  = {start_reg[15:8], q_item.rx_byte};
      FLD_START_HI: start_reg_next  = {q_item.rx_byte, start_reg[7:0]};
      default:      ;
    endcase
    crc_next  = q_item.crc_on ? crc_feed(crc, tail[7:0]) : crc;
    tail_next = {q_item.rx_byte, tail[15:8]};
  end

  // Result for the byte: a word before the CRC bytes, or the verdict.
  always_comb begin
    res    = '0;
    res_we = 1'b0;
    if (q_item.eop) begin
      res_we   = 1'b1;
      res.kind = KIND_VERDICT;
      if (size < MIN_SIZE) begin
        res.status = ST_SHORT;
      end else if (prefix_bad_next) begin
        res.status = ST_PREFIX;
      end else if (size != {2'b00, decl_len_next} + FRAME_EXTRA) begin
        res.status = ST_LENGTH;
      end else if (tcp_func_next != data_func) begin
        res.status = ST_TCP_FUNC;
      end else if (tail_next != crc_next) begin
        res.status = ST_CRC;
      end else if (dev_func_next != read_func) begin
        res.status = ST_DEV_FUNC;
      end else begin
        res.status = ST_OK;
      end
    end else if (q_item.field == FLD_WORD_HI &&
                 {1'b0, q_item.pos} < {2'b00, decl_len} + CRC_OFFSET) begin
      res_we          = 1'b1;
      res.kind        = KIND_WORD;
      res.reg_address = start_reg + word_off[16:1];
      res.reg_value   = {q_item.rx_byte, low_hold};
    end
  end

  // Packet state; everything returns to reset after the final byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      decl_len   <= 16'd0;
      prefix_bad <= 1'b0;
      tcp_func   <= 8'd0;
      dev_func   <= 8'd0;
      start_reg  <= 16'd0;
      low_hold   <= 8'd0;
      crc        <= CRC_INIT;
      tail       <= 16'd0;
    end else if (q_take) begin
      if (q_item.eop) begin
        decl_len   <= 16'd0;
        prefix_bad <= 1'b0;
        tcp_func   <= 8'd0;
        dev_func   <= 8'd0;
        start_reg  <= 16'd0;
        low_hold   <= 8'd0;
        crc        <= CRC_INIT;
        tail       <= 16'd0;
      end else begin
        decl_len   <= decl_len_next;
        prefix_bad <= prefix_bad_next;
        tcp_func   <= tcp_func_next;
        dev_func   <= dev_func_next;
        start_reg  <= start_reg_next;
        crc        <= crc_next;
        tail       <= tail_next;
        if (q_item.field == FLD_WORD_LO) begin
          low_hold <= q_item.rx_byte;
        end
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      data_func <= 8'd194;
      read_func <= 8'd4;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_DATA_FUNC) begin
        data_func <= cfg_data;
      end else if (cfg_index == CFG_READ_FUNC) begin
        read_func <= cfg_data;
      end
    end
  end

  // Result queue control.
  always_ff @(posedge clk) begin
    if (rst) begin
      r_wr    <= 1'b0;
      r_rd    <= 1'b0;
      r_count <= 2'd0;
    end else begin
      if (q_take && res_we) begin
        r_wr <= ~r_wr;
      end
      if (deq) begin
        r_rd <= ~r_rd;
      end
      case ({q_take && res_we, deq})
        2'b10:   r_count <= r_count + 2'd1;
        2'b01:   r_count <= r_count - 2'd1;
        default: r_count <= r_count;
      endcase
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (q_take && res_we) begin
      r_mem[r_wr] <= res;
    end
  end

endmodule

>>> hdl/inverter_frame_deframer.sv
// Top level of the framed register-response deframer.
//
// Packet bytes enter through a queue-style port: an item is taken when push
// is high and full is low, end_of_packet marks the last byte of a packet.
// Results leave through a queue-style port: the oldest result sits on kind,
// reg_address, reg_value and status while empty is low, and pop removes it.
// A register word comes out for each completed word before the CRC bytes;
// the last byte of a packet yields one verdict and nothing else.
// A result reaches the result ports by way of both queues: its byte is first
// written to the front end's queue, then its result lands in the result queue.
// Throughput is one byte per cycle while full stays low; the back end's unrolled
// byte-wide CRC and field capture handle each byte whole, without iteration.
// When the receiver stops popping, the two-entry result queue fills, the
// back end stops draining its input queue, and full rises once that queue
// holds two bytes. No item is lost.
// Configuration is written through cfg_valid/cfg_ready (always ready) with
// cfg_index 0 for the transport function and 1 for the device function.
// A synchronous reset empties both queues, restores the register defaults
// and starts a fresh packet.
module inverter_frame_deframer import ifd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  input  logic        end_of_packet,
  output logic        empty,
  input  logic        pop,
  output logic        kind,
  output logic [15:0] reg_address,
  output logic [15:0] reg_value,
  output logic [2:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic    q_valid;
  item_t   q_item;
  logic    q_take;
  result_t res_head;

  assign cfg_ready   = 1'b1;
  assign kind        = res_head.kind;
  assign reg_address = res_head.reg_address;
  assign reg_value   = res_head.reg_value;
  assign status      = res_head.status;

  // Byte classification and input queue.
  ifd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .rx_byte       (rx_byte),
    .end_of_packet (end_of_packet),
    .full          (full),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_take        (q_take)
  );

  // Field checks, CRC and result queue.
  ifd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pop       (pop),
    .empty     (empty),
    .res_head  (res_head)
  );

endmodule
